[src/csd_pkg.sv]
// Shared types and constants for the column standardiser.
package csd_pkg;

  // command codes of an input beat
  localparam logic [2:0] CMD_CLEAR  = 3'd0;
  localparam logic [2:0] CMD_ACCUM  = 3'd1;
  localparam logic [2:0] CMD_FINAL  = 3'd2;
  localparam logic [2:0] CMD_NORM   = 3'd3;
  localparam logic [2:0] CMD_UNNORM = 3'd4;

  // register select on the APB port (paddr[2])
  localparam logic REG_SKIP_EN = 1'b0;

  // 1.0 in Q7.8 / Q8.8
  localparam logic [15:0] ONE_Q88 = 16'd256;

  // iteration count field of the serial unit
  localparam int LEN_BITS = 7;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [3:0]         column;
    logic signed [15:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [15:0] value_out;
    logic [3:0]         column_out;
    logic               saturated;
    logic               zero_spread;
    logic               column_skipped;
  } out_t;

  typedef enum logic [1:0] {
    SU_DIV,
    SU_MUL,
    SU_SQRT
  } su_op_e;

  typedef struct packed {
    logic                start;
    su_op_e              op;
    logic [LEN_BITS-1:0] len;
  } su_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } su_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UNN,
    S_NDIV,
    S_FRD,
    S_FCOL,
    S_FQ,
    S_FM1,
    S_FM2,
    S_FA,
    S_FV,
    S_FS,
    S_OUT
  } csd_state_e;

endpackage

[src/csd_serial_unit.sv]
// Bit-serial divide / multiply / square root unit shared by the sequencer.
module csd_serial_unit #(
  parameter int W = 46
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csd_pkg::su_ctl_t   ctl_i,
  input  logic [W-1:0]       opa_i,
  input  logic [W-1:0]       opb_i,
  output csd_pkg::su_stat_t  stat_o,
  output logic [W-1:0]       res_o,
  output logic [W+1:0]       rem_o
);
  import csd_pkg::*;

  // opa is consumed MSB first: callers left-align it
  logic [W-1:0]        a_q, b_q, res_q, a_d, res_d;
  logic [W+1:0]        acc_q, acc_d;
  logic [LEN_BITS-1:0] cnt_q;
  su_op_e              op_q;
  logic                done_q;
  logic                busy;

  logic [W+1:0] sh_div, sh_sq, trial_sq, addend;

  assign busy = (cnt_q != '0);

  always_comb begin
    sh_div   = {acc_q[W:0], a_q[W-1]};
    sh_sq    = {acc_q[W-1:0], a_q[W-1:W-2]};
    trial_sq = {res_q, 2'b01};
    addend   = a_q[W-1] ? {2'b00, b_q} : '0;
    a_d      = a_q;
    acc_d    = acc_q;
    res_d    = res_q;
    case (op_q)
      SU_DIV: begin
        a_d = {a_q[W-2:0], 1'b0};
        if (sh_div >= {2'b00, b_q}) begin
          acc_d = sh_div - {2'b00, b_q};
          res_d = {res_q[W-2:0], 1'b1};
        end else begin
          acc_d = sh_div;
          res_d = {res_q[W-2:0], 1'b0};
        end
      end
      SU_MUL: begin
        a_d   = {a_q[W-2:0], 1'b0};
        acc_d = {acc_q[W:0], 1'b0} + addend;
      end
      SU_SQRT: begin
        a_d = {a_q[W-3:0], 2'b00};
        if (sh_sq >= trial_sq) begin
          acc_d = sh_sq - trial_sq;
          res_d = {res_q[W-2:0], 1'b1};
        end else begin
          acc_d = sh_sq;
          res_d = {res_q[W-2:0], 1'b0};
        end
      end
      default: begin
        a_d = a_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      op_q   <= SU_DIV;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == LEN_BITS'(1));
      if (ctl_i.start) begin
        cnt_q <= ctl_i.len;
        op_q  <= ctl_i.op;
      end else if (busy) begin
        cnt_q <= cnt_q - LEN_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q   <= opa_i;
      b_q   <= opb_i;
      acc_q <= '0;
      res_q <= '0;
    end else if (busy) begin
      a_q   <= a_d;
      acc_q <= acc_d;
      res_q <= res_d;
    end
  end

  assign stat_o = '{busy: busy, done: done_q};
  assign res_o  = res_q;
  assign rem_o  = acc_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy)
    else $error("serial unit started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy))
    else $error("done without a run");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && op_q == SU_DIV && b_q != '0) |-> (acc_q < {2'b00, b_q}))
    else $error("partial remainder not below divisor");

endmodule

[src/column_standardiser.sv]
// Column standardiser top level: stores, sequencer, APB register and beat registers.
//
//  channel   dir  handshake               payload
//  in        in   in_valid_i / in_stall_o  in_data_i  (cmd, column, sample)
//  out       out  out_valid_o / out_stall_i out_data_o (value, column, flags)
//  cfg       in   psel/penable/pwrite      paddr, pwdata -> skip_enable
//
// Clear, accumulate and bad beats go from decode straight to output; unnormalise passes S_UNN.
// Normalise with a nonzero spread runs a 25-step serial divide.
// Finalise walks every column; each column that is not skipped and holds
// samples goes through the serial unit: divide, two multiplies, two divides, sqrt.
// Reset clears all column state at once (valid bits); skip_enable resets to 0.
// in_stall_o is high while a beat is in work; a held output beat blocks only
// the finish of the next one.
module column_standardiser #(
  parameter int COLUMNS    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  csd_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output csd_pkg::out_t  out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import csd_pkg::*;

  localparam int CB   = COUNT_BITS;
  localparam int SB   = CB + 15;
  localparam int SUMW = CB + 16;
  localparam int QB   = CB + 30;
  localparam int TB   = 2 * CB + 15;
  localparam int W    = (TB > QB) ? TB : QB;
  localparam int IW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  typedef struct packed {
    logic [CB-1:0]          cnt;
    logic signed [SUMW-1:0] sum;
    logic [QB-1:0]          sq;
    logic                   mark;
  } st_ent_t;

  typedef struct packed {
    logic signed [15:0] mean;
    logic [15:0]        spread;
  } rs_ent_t;

  // ---------------- configuration ----------------
  logic skip_en_q;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SKIP_EN);
  assign prdata = (paddr[2] == REG_SKIP_EN) ? {31'b0, skip_en_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_en_q <= 1'b0;
    end else if (cfg_we) begin
      skip_en_q <= pwdata[0];
    end
  end

  // ---------------- state and beat registers ----------------
  csd_state_e state_q, state_d;
  logic [2:0]         cmd_q;
  logic [3:0]         col_q;
  logic signed [15:0] x_q;
  logic [IW-1:0]      fidx_q;
  logic [IW-1:0]      col_idx, rd_addr;
  logic               col_ok, cmd_ok, last_col;

  assign col_idx  = IW'(col_q);
  assign col_ok   = (32'(col_q) < COLUMNS);
  assign cmd_ok   = col_ok && (cmd_q <= CMD_UNNORM);
  assign last_col = (fidx_q == IW'(COLUMNS - 1));
  assign in_stall_o = (state_q != S_IDLE);

  // ---------------- column stores ----------------
  st_ent_t st_mem [COLUMNS];
  rs_ent_t rs_mem [COLUMNS];
  logic [COLUMNS-1:0] st_vld_q, rs_vld_q;
  st_ent_t st_rd_q, st_cur, st_wdata;
  rs_ent_t rs_rd_q, rs_cur, rs_wdata;
  logic    st_rv_q, rs_rv_q;
  logic    st_we, rs_we, clr;
  logic [IW-1:0] rs_widx;

  always_comb begin
    case (state_q)
      S_IDLE:                                         rd_addr = IW'(in_data_i.column);
      S_FRD, S_FCOL, S_FQ, S_FM1, S_FM2, S_FA, S_FV, S_FS: rd_addr = fidx_q;
      default:                                        rd_addr = col_idx;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[col_idx] <= st_wdata;
    end
    if (rs_we) begin
      rs_mem[rs_widx] <= rs_wdata;
    end
    st_rd_q <= st_mem[rd_addr];
    rs_rd_q <= rs_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
      rs_vld_q <= '0;
      st_rv_q  <= 1'b0;
      rs_rv_q  <= 1'b0;
    end else begin
      if (clr) begin
        st_vld_q <= '0;
        rs_vld_q <= '0;
      end else begin
        if (st_we) st_vld_q[col_idx] <= 1'b1;
        if (rs_we) rs_vld_q[rs_widx] <= 1'b1;
      end
      st_rv_q <= st_vld_q[rd_addr];
      rs_rv_q <= rs_vld_q[rd_addr];
    end
  end

  // entries never written since clear read as the reset values
  assign st_cur = st_rv_q ? st_rd_q : '{cnt: '0, sum: '0, sq: '0, mark: 1'b1};
  assign rs_cur = rs_rv_q ? rs_rd_q : '{mean: '0, spread: '0};

  // ---------------- accumulate datapath ----------------
  logic signed [31:0] x_sq;
  logic               cnt_full, x_trivial, mark_new;

  assign x_sq      = x_q * x_q;
  assign cnt_full  = (st_cur.cnt == '1);
  assign x_trivial = (x_q == 16'sd0) || (x_q == $signed(ONE_Q88)) ||
                     (x_q == -$signed(ONE_Q88));
  assign mark_new  = cnt_full ? st_cur.mark : (st_cur.mark && x_trivial);

  always_comb begin
    st_wdata.cnt  = st_cur.cnt + CB'(1);
    st_wdata.sum  = st_cur.sum + SUMW'(x_q);
    st_wdata.sq   = st_cur.sq + QB'(x_sq[30:0]);
    st_wdata.mark = mark_new;
  end

  // ---------------- normalise datapath ----------------
  logic signed [16:0] n_diff;
  logic [24:0]        n_mag;
  logic               n_neg, n_rnd;
  logic [26:0]        n_q;

  assign n_diff = 17'(x_q) - 17'(rs_cur.mean);
  assign n_neg  = n_diff[16];
  assign n_mag  = n_neg ? 25'({~n_diff + 17'sd1, 8'b0}) : 25'({n_diff, 8'b0});

  // ---------------- unnormalise datapath ----------------
  logic signed [32:0] prod_q;
  logic               u_neg;
  logic [32:0]        u_mag;
  logic [24:0]        u_qm;
  logic signed [27:0] u_sum;

  assign u_neg = prod_q[32];
  assign u_mag = u_neg ? 33'(-prod_q) : 33'(prod_q);
  assign u_qm  = 25'((u_mag + 33'd128) >> 8);
  assign u_sum = (u_neg ? -$signed({3'b000, u_qm}) : $signed({3'b000, u_qm})) +
                 28'(rs_cur.mean);

  // ---------------- finalise datapath ----------------
  su_ctl_t      su_ctl;
  su_stat_t     su_stat;
  logic [W-1:0] su_a, su_b, su_res;
  logic [W+1:0] su_rem;

  logic               f_neg, f_skip, f_rnd;
  logic [SB-1:0]      f_s;
  logic [CB-1:0]      r_q;
  logic [QB-1:0]      d_q, f_e;
  logic signed [15:0] mean_q, f_mean;
  logic [16:0]        f_mq;
  logic [15:0]        f_root, f_dev;

  assign f_neg  = st_cur.sum[SUMW-1];
  assign f_s    = SB'(f_neg ? -st_cur.sum : st_cur.sum);
  assign f_skip = skip_en_q && st_cur.mark;
  assign f_rnd  = ({1'b0, su_rem[CB-1:0], 1'b0} >= {2'b00, st_cur.cnt});
  assign f_mq   = 17'(su_res[15:0]) + 17'(f_rnd);
  assign f_mean = f_neg ? -$signed(f_mq[15:0]) : $signed(f_mq[15:0]);
  assign f_e    = d_q - QB'(su_res) - QB'(su_rem != '0);
  assign f_root = su_res[15:0];
  assign f_dev  = f_root + 16'(su_rem > {{(W-14){1'b0}}, f_root});

  assign n_rnd  = ({su_rem[15:0], 1'b0} >= {1'b0, rs_cur.spread});
  assign n_q    = 27'(su_res[25:0]) + 27'(n_rnd);

  csd_serial_unit #(.W(W)) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (su_ctl),
    .opa_i  (su_a),
    .opb_i  (su_b),
    .stat_o (su_stat),
    .res_o  (su_res),
    .rem_o  (su_rem)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    su_ctl   = '{start: 1'b0, op: SU_DIV, len: '0};
    su_a     = '0;
    su_b     = '0;
    st_we    = 1'b0;
    rs_we    = 1'b0;
    rs_widx  = fidx_q;
    rs_wdata = '{mean: '0, spread: '0};
    clr      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        state_d = S_OUT;
        if (cmd_q == CMD_CLEAR) begin
          clr = 1'b1;
        end else if (cmd_ok) begin
          case (cmd_q)
            CMD_ACCUM: st_we = !cnt_full;
            CMD_FINAL: state_d = S_FRD;
            CMD_NORM: begin
              if (rs_cur.spread != '0) begin
                su_ctl  = '{start: 1'b1, op: SU_DIV, len: LEN_BITS'(25)};
                su_a    = W'(n_mag) << (W - 25);
                su_b    = W'(rs_cur.spread);
                state_d = S_NDIV;
              end
            end
            CMD_UNNORM: begin
              if (rs_cur.spread != '0) state_d = S_UNN;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_NDIV: begin
        if (su_stat.done) state_d = S_OUT;
      end
      S_UNN: state_d = S_OUT;
      S_FRD: state_d = S_FCOL;
      S_FCOL: begin
        if (f_skip || st_cur.cnt == '0) begin
          rs_we    = 1'b1;
          rs_wdata = '{mean: '0, spread: (f_skip ? ONE_Q88 : 16'd0)};
          state_d  = last_col ? S_OUT : S_FRD;
        end else begin
          su_ctl  = '{start: 1'b1, op: SU_DIV, len: LEN_BITS'(SB)};
          su_a    = W'(f_s) << (W - SB);
          su_b    = W'(st_cur.cnt);
          state_d = S_FQ;
        end
      end
      S_FQ: begin
        if (su_stat.done) begin
          // q * s
          su_ctl  = '{start: 1'b1, op: SU_MUL, len: LEN_BITS'(16)};
          su_a    = W'(su_res[15:0]) << (W - 16);
          su_b    = W'(f_s);
          state_d = S_FM1;
        end
      end
      S_FM1: begin
        if (su_stat.done) begin
          // r * s
          su_ctl  = '{start: 1'b1, op: SU_MUL, len: LEN_BITS'(CB)};
          su_a    = W'(r_q) << (W - CB);
          su_b    = W'(f_s);
          state_d = S_FM2;
        end
      end
      S_FM2: begin
        if (su_stat.done) begin
          su_ctl  = '{start: 1'b1, op: SU_DIV, len: LEN_BITS'(TB)};
          su_a    = W'(su_rem[TB-1:0]) << (W - TB);
          su_b    = W'(st_cur.cnt);
          state_d = S_FA;
        end
      end
      S_FA: begin
        if (su_stat.done) begin
          su_ctl  = '{start: 1'b1, op: SU_DIV, len: LEN_BITS'(QB)};
          su_a    = W'(f_e) << (W - QB);
          su_b    = W'(st_cur.cnt);
          state_d = S_FV;
        end
      end
      S_FV: begin
        if (su_stat.done) begin
          su_ctl  = '{start: 1'b1, op: SU_SQRT, len: LEN_BITS'(16)};
          su_a    = W'(su_res[31:0]) << (W - 32);
          state_d = S_FS;
        end
      end
      S_FS: begin
        if (su_stat.done) begin
          rs_we    = 1'b1;
          rs_wdata = '{mean: mean_q, spread: f_dev};
          state_d  = last_col ? S_OUT : S_FRD;
        end
      end
      S_OUT: begin
        if (!out_valid_o || !out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- result registers ----------------
  logic signed [15:0] rv_q;
  logic               rsat_q, rzs_q, rsk_q;
  out_t               out_q;
  logic               out_valid_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q  <= in_data_i.cmd;
        col_q  <= in_data_i.column;
        x_q    <= in_data_i.sample;
        fidx_q <= '0;
      end
      S_DECODE: begin
        rv_q   <= '0;
        rsat_q <= 1'b0;
        rzs_q  <= 1'b0;
        rsk_q  <= 1'b0;
        prod_q <= x_q * $signed({1'b0, rs_cur.spread});
        if (cmd_ok && cmd_q == CMD_ACCUM) begin
          rzs_q <= (rs_cur.spread == '0);
          rsk_q <= skip_en_q && mark_new;
        end else if (cmd_ok && (cmd_q == CMD_NORM || cmd_q == CMD_UNNORM)) begin
          rzs_q <= (rs_cur.spread == '0);
          rsk_q <= skip_en_q && st_cur.mark;
        end
      end
      S_NDIV: begin
        if (su_stat.done) begin
          if (!n_neg) begin
            rsat_q <= (n_q > 27'd32767);
            rv_q   <= (n_q > 27'd32767) ? 16'sd32767 : $signed(n_q[15:0]);
          end else begin
            rsat_q <= (n_q > 27'd32768);
            rv_q   <= (n_q > 27'd32768) ? -16'sd32768 : -$signed(n_q[15:0]);
          end
        end
      end
      S_UNN: begin
        if (u_sum > 28'sd32767) begin
          rsat_q <= 1'b1;
          rv_q   <= 16'sd32767;
        end else if (u_sum < -28'sd32768) begin
          rsat_q <= 1'b1;
          rv_q   <= -16'sd32768;
        end else begin
          rv_q <= u_sum[15:0];
        end
      end
      S_FCOL: begin
        if (f_skip || st_cur.cnt == '0) begin
          if (fidx_q == col_idx) begin
            rzs_q <= !f_skip;
            rsk_q <= f_skip;
          end
          if (!last_col) fidx_q <= fidx_q + IW'(1);
        end
      end
      S_FQ: begin
        if (su_stat.done) begin
          r_q    <= su_rem[CB-1:0];
          mean_q <= f_mean;
        end
      end
      S_FM1: begin
        if (su_stat.done) d_q <= st_cur.sq - QB'(su_rem);
      end
      S_FS: begin
        if (su_stat.done) begin
          if (fidx_q == col_idx) begin
            rzs_q <= (f_dev == '0);
            rsk_q <= 1'b0;
          end
          if (!last_col) fidx_q <= fidx_q + IW'(1);
        end
      end
      default: begin
        rv_q <= rv_q;
      end
    endcase
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && state_d == S_IDLE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && state_d == S_IDLE) begin
      out_q <= '{value_out: rv_q, column_out: col_q, saturated: rsat_q,
                 zero_spread: rzs_q, column_skipped: rsk_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DECODE))
    else $error("accepted beat not decoded");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i) |=> (state_q == S_OUT))
    else $error("result finished over a held output beat");

  a_unit_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    su_stat.busy |-> (state_q == S_NDIV || state_q == S_FQ || state_q == S_FM1 ||
                      state_q == S_FM2 || state_q == S_FA || state_q == S_FV ||
                      state_q == S_FS))
    else $error("serial unit running outside a wait state");

endmodule
